// ===== src/apss_pkg.sv =====
// ============================================================================
// apss_pkg
// Shared types, codes and result decoding for the ATA PIO sector sequencer.
// ============================================================================
`default_nettype none

package apss_pkg;

    // task-file register offsets
    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LBA_LO  = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI  = 3'd5;
    localparam logic [2:0] REG_SELECT  = 3'd6;
    localparam logic [2:0] REG_CMD_ST  = 3'd7;

    // input item kinds
    localparam logic [1:0] CMD_START_RD  = 2'd0;
    localparam logic [1:0] CMD_START_WR  = 2'd1;
    localparam logic [1:0] CMD_BUS_REPLY = 2'd2;
    localparam logic [1:0] CMD_HOST_WORD = 2'd3;

    // result actions
    localparam logic [2:0] ACT_BYTE_RD = 3'd0;
    localparam logic [2:0] ACT_WORD_RD = 3'd1;
    localparam logic [2:0] ACT_BYTE_WR = 3'd2;
    localparam logic [2:0] ACT_WORD_WR = 3'd3;
    localparam logic [2:0] ACT_HOST    = 3'd4;
    localparam logic [2:0] ACT_DONE    = 3'd5;

    // outcomes carried on done
    localparam logic [1:0] OC_SUCCESS     = 2'd0;
    localparam logic [1:0] OC_DEV_ERROR   = 2'd1;
    localparam logic [1:0] OC_BSY_TIMEOUT = 2'd2;
    localparam logic [1:0] OC_DRQ_TIMEOUT = 2'd3;

    // device constants
    localparam logic [7:0]  SEL_LBA_BASE      = 8'hE0;
    localparam logic [7:0]  ATA_READ_SECTORS  = 8'h20;
    localparam logic [7:0]  ATA_WRITE_SECTORS = 8'h30;
    localparam logic [7:0]  ST_BSY            = 8'h80;
    localparam logic [7:0]  ST_DRQ            = 8'h08;
    localparam logic [7:0]  ST_ERR            = 8'h01;
    localparam logic [16:0] POLL_LIMIT_RESET  = 17'd100000;
    localparam logic [8:0]  SECTOR_WORDS      = 9'd256;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_BSY,
        PH_WAIT_DRQ,
        PH_READ_DATA,
        PH_WRITE_DATA
    } t_phase;

    // one input item's worth of results, expanded a beat at a time downstream
    typedef enum logic [2:0] {
        BK_STATUS_RD,
        BK_TASKFILE,
        BK_DONE,
        BK_WORD_RD,
        BK_HOST_NEXT,
        BK_HOST_DONE,
        BK_WR_WORD,
        BK_WR_DONE
    } t_burst_kind;

    typedef struct packed {
        t_burst_kind kind;
        logic        is_write;
        logic [27:0] lba;
        logic [15:0] word;
        logic [1:0]  outcome;
    } t_burst;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  reg_offset;
        logic [15:0] value;
        logic [1:0]  outcome;
        logic        last;
    } t_result;

    function automatic logic [2:0] burst_last_idx(input t_burst_kind kind);
        logic [2:0] li;
        li = 3'd0;
        case (kind) inside
            BK_TASKFILE:                           li = 3'd6;
            BK_HOST_NEXT, BK_HOST_DONE, BK_WR_DONE: li = 3'd1;
            default:                               li = 3'd0;
        endcase
        return li;
    endfunction

    function automatic t_result burst_result(input t_burst b, input logic [2:0] idx);
        t_result r;
        r.action     = ACT_BYTE_RD;
        r.reg_offset = REG_DATA;
        r.value      = 16'h0000;
        r.outcome    = OC_SUCCESS;
        r.last       = (idx == burst_last_idx(b.kind));
        case (b.kind)
            BK_STATUS_RD: begin
                r.reg_offset = REG_CMD_ST;
            end
            BK_TASKFILE: begin
                r.action = ACT_BYTE_WR;
                case (idx)
                    3'd0: begin
                        r.reg_offset = REG_SELECT;
                        r.value      = {8'h00, SEL_LBA_BASE | {4'h0, b.lba[27:24]}};
                    end
                    3'd1: begin
                        r.reg_offset = REG_COUNT;
                        r.value      = 16'd1;
                    end
                    3'd2: begin
                        r.reg_offset = REG_LBA_LO;
                        r.value      = {8'h00, b.lba[7:0]};
                    end
                    3'd3: begin
                        r.reg_offset = REG_LBA_MID;
                        r.value      = {8'h00, b.lba[15:8]};
                    end
                    3'd4: begin
                        r.reg_offset = REG_LBA_HI;
                        r.value      = {8'h00, b.lba[23:16]};
                    end
                    3'd5: begin
                        r.reg_offset = REG_CMD_ST;
                        r.value      = {8'h00, b.is_write ? ATA_WRITE_SECTORS
                                                          : ATA_READ_SECTORS};
                    end
                    default: begin
                        // closing status read after the command byte
                        r.action     = ACT_BYTE_RD;
                        r.reg_offset = REG_CMD_ST;
                    end
                endcase
            end
            BK_DONE: begin
                r.action  = ACT_DONE;
                r.outcome = b.outcome;
            end
            BK_WORD_RD: begin
                r.action = ACT_WORD_RD;
            end
            BK_HOST_NEXT: begin
                if (idx == 3'd0) begin
                    r.action = ACT_HOST;
                    r.value  = b.word;
                end else begin
                    r.action = ACT_WORD_RD;
                end
            end
            BK_HOST_DONE: begin
                if (idx == 3'd0) begin
                    r.action = ACT_HOST;
                    r.value  = b.word;
                end else begin
                    r.action = ACT_DONE;
                end
            end
            BK_WR_WORD: begin
                r.action = ACT_WORD_WR;
                r.value  = b.word;
            end
            default: begin
                if (idx == 3'd0) begin
                    r.action = ACT_WORD_WR;
                    r.value  = b.word;
                end else begin
                    r.action = ACT_DONE;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/apss_phase_ctrl.sv =====
// ============================================================================
// apss_phase_ctrl
// Phase machine: takes one item per beat, updates the transfer state and
// hands a burst descriptor to the result generator.
// ============================================================================
`default_nettype none

module apss_phase_ctrl
    import apss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [27:0] i_lba,
    input  wire logic [15:0] i_word,
    output logic             o_burst_valid,
    output t_burst           o_burst
);

    t_phase      r_phase, n_phase;
    logic        r_is_write, n_is_write;
    logic [27:0] r_lba, n_lba;
    logic [16:0] r_polls_left, n_polls_left;
    logic [8:0]  r_words_left, n_words_left;
    logic [16:0] r_poll_limit;

    logic [7:0]  status;
    logic [16:0] budget;
    logic [8:0]  words_dec;

    assign status    = i_word[7:0];
    // a zero limit still allows the first read
    assign budget    = (r_poll_limit == 17'd0) ? 17'd0 : r_poll_limit - 17'd1;
    assign words_dec = (r_words_left == 9'd0) ? 9'd0 : r_words_left - 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_is_write   <= 1'b0;
            r_lba        <= 28'd0;
            r_polls_left <= 17'd0;
            r_words_left <= 9'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_is_write   <= n_is_write;
            r_lba        <= n_lba;
            r_polls_left <= n_polls_left;
            r_words_left <= n_words_left;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd == CMD_START_RD || i_cmd == CMD_START_WR) begin
                    n_phase = PH_WAIT_BSY;
                end
            end
            PH_WAIT_BSY: begin
                if (i_cmd == CMD_BUS_REPLY) begin
                    if ((status & ST_BSY) == 8'h00) begin
                        n_phase = PH_WAIT_DRQ;
                    end else if (r_polls_left == 17'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_WAIT_DRQ: begin
                if (i_cmd == CMD_BUS_REPLY) begin
                    if ((status & ST_ERR) != 8'h00) begin
                        n_phase = PH_IDLE;
                    end else if ((status & ST_DRQ) != 8'h00) begin
                        n_phase = r_is_write ? PH_WRITE_DATA : PH_READ_DATA;
                    end else if (r_polls_left == 17'd0) begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            PH_READ_DATA: begin
                if (i_cmd == CMD_BUS_REPLY && words_dec == 9'd0) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_WRITE_DATA: begin
                if (i_cmd == CMD_HOST_WORD && words_dec == 9'd0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    // state updates and burst descriptor
    always_comb begin
        n_is_write       = r_is_write;
        n_lba            = r_lba;
        n_polls_left     = r_polls_left;
        n_words_left     = r_words_left;
        o_burst_valid    = 1'b0;
        o_burst.kind     = BK_STATUS_RD;
        o_burst.is_write = r_is_write;
        o_burst.lba      = r_lba;
        o_burst.word     = i_word;
        o_burst.outcome  = OC_SUCCESS;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd == CMD_START_RD || i_cmd == CMD_START_WR) begin
                    n_is_write    = i_cmd[0];
                    n_lba         = i_lba;
                    n_polls_left  = budget;
                    o_burst_valid = i_accept;
                end
            end
            PH_WAIT_BSY: begin
                if (i_cmd == CMD_BUS_REPLY) begin
                    o_burst_valid = i_accept;
                    if ((status & ST_BSY) == 8'h00) begin
                        n_polls_left = budget;
                        o_burst.kind = BK_TASKFILE;
                    end else if (r_polls_left == 17'd0) begin
                        o_burst.kind    = BK_DONE;
                        o_burst.outcome = OC_BSY_TIMEOUT;
                    end else begin
                        n_polls_left = r_polls_left - 17'd1;
                    end
                end
            end
            PH_WAIT_DRQ: begin
                if (i_cmd == CMD_BUS_REPLY) begin
                    o_burst_valid = i_accept;
                    if ((status & ST_ERR) != 8'h00) begin
                        o_burst.kind    = BK_DONE;
                        o_burst.outcome = OC_DEV_ERROR;
                    end else if ((status & ST_DRQ) != 8'h00) begin
                        n_words_left = SECTOR_WORDS;
                        o_burst.kind = BK_WORD_RD;
                        // write side waits silently for host words
                        if (r_is_write) begin
                            o_burst_valid = 1'b0;
                        end
                    end else if (r_polls_left == 17'd0) begin
                        o_burst.kind    = BK_DONE;
                        o_burst.outcome = OC_DRQ_TIMEOUT;
                    end else begin
                        n_polls_left = r_polls_left - 17'd1;
                    end
                end
            end
            PH_READ_DATA: begin
                if (i_cmd == CMD_BUS_REPLY) begin
                    o_burst_valid = i_accept;
                    n_words_left  = words_dec;
                    o_burst.kind  = (words_dec == 9'd0) ? BK_HOST_DONE : BK_HOST_NEXT;
                end
            end
            PH_WRITE_DATA: begin
                if (i_cmd == CMD_HOST_WORD) begin
                    o_burst_valid = i_accept;
                    n_words_left  = words_dec;
                    o_burst.kind  = (words_dec == 9'd0) ? BK_WR_DONE : BK_WR_WORD;
                end
            end
            default: begin
                o_burst_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/apss_result_gen.sv =====
// ============================================================================
// apss_result_gen
// Holds one burst descriptor and plays it out one result per beat through
// an output register.
// ============================================================================
`default_nettype none

module apss_result_gen
    import apss_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_burst_valid,
    input  wire t_burst i_burst,
    output logic        o_burst_ready,
    input  wire logic   i_m_ready,
    output logic        o_m_valid,
    output t_result     o_result
);

    logic       r_desc_valid;
    t_burst     r_desc;
    logic [2:0] r_idx;
    logic       r_out_valid;
    t_result    r_out;

    logic load;
    logic cur_last;

    assign load          = r_desc_valid && (!r_out_valid || i_m_ready);
    assign cur_last      = (r_idx == burst_last_idx(r_desc.kind));
    // slot frees in the cycle its final result moves to the output register
    assign o_burst_ready = !r_desc_valid || (load && cur_last);
    assign o_m_valid     = r_out_valid;
    assign o_result      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc_valid <= 1'b0;
            r_idx        <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_burst_valid) begin
                r_desc_valid <= 1'b1;
                r_idx        <= 3'd0;
            end else if (load && cur_last) begin
                r_desc_valid <= 1'b0;
            end else if (load) begin
                r_idx <= r_idx + 3'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_burst_valid) begin
            r_desc <= i_burst;
        end
        if (load) begin
            r_out <= burst_result(r_desc, r_idx);
        end
    end

endmodule

`default_nettype wire

// ===== src/ata_pio_sector_sequencer.sv =====
// ============================================================================
// ata_pio_sector_sequencer
// Host-side sequencer for a single-sector ATA PIO LBA28 read or write.
// ============================================================================
//  channel   dir  beat content
//  s_axis    in   tuser: cmd; tdata: lba, data_word
//  m_axis    out  tuser: action; tdata: reg_offset, value, outcome; tlast: last
//  cfg       in   i_cfg_data: status_poll_limit
//
//  An input beat is taken in any cycle the burst descriptor slot is free or
//  is releasing its final result; state updates in that same cycle.
//  Results leave one per beat via the output register: none to seven per item,
//  seven for the task-file sequence, so output pacing sets the long-run rate.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A stalled m_axis holds its beat; s_axis keeps accepting until the slot fills.
// ============================================================================
`default_nettype none

module ata_pio_sector_sequencer
    import apss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // [27:0] lba, [43:28] data_word, rest zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [2:0] reg_offset, [18:3] value, [20:19] outcome
    output logic [2:0]       m_axis_tuser,  // [2:0] action
    output logic             m_axis_tlast
);

    logic    accept;
    logic    burst_valid;
    t_burst  burst;
    t_result result;

    assign o_cfg_ready = 1'b1;
    assign accept      = s_axis_tvalid && s_axis_tready;

    apss_phase_ctrl u_phase (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_cmd         (s_axis_tuser),
        .i_lba         (s_axis_tdata[27:0]),
        .i_word        (s_axis_tdata[43:28]),
        .o_burst_valid (burst_valid),
        .o_burst       (burst)
    );

    apss_result_gen u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_burst_valid (burst_valid),
        .i_burst       (burst),
        .o_burst_ready (s_axis_tready),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_result      (result)
    );

    assign m_axis_tdata = {3'b000, result.outcome, result.value, result.reg_offset};
    assign m_axis_tuser = result.action;
    assign m_axis_tlast = result.last;

endmodule

`default_nettype wire

// ===== src/apss_checker.sv =====
// ============================================================================
// apss_checker
// Port-level checks on the sequencer's result stream.
// ============================================================================
`default_nettype none

module apss_checker
    import apss_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    a_action_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ACT_DONE))
        else $error("undefined action code");

    // done always closes the item's results
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ACT_DONE |-> m_axis_tlast)
        else $error("done without last");

    a_outcome_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_DONE |-> m_axis_tdata[20:19] == OC_SUCCESS)
        else $error("outcome set on a non-done result");

endmodule

bind ata_pio_sector_sequencer apss_checker u_apss_checker (.*);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the ATA PIO sector sequencer. Directed cases cover
// poll timeouts, device errors, ignored items and address extremes; random
// transfers, with noise items, idle gaps and output stalls, then exercise
// a complete sector transfer. Every result beat is checked field by
// field against a cycle-free model of the sequencer kept in the bench.
// ============================================================================
`default_nettype none

module tb_top;
    import apss_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 340;
    localparam logic [16:0] POLL_LIMIT_MAX = 17'h1FFFF;

    typedef enum {XF_SUCCESS, XF_DEV_ERROR, XF_BSY_TIMEOUT, XF_DRQ_TIMEOUT} t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [27:0] lba, [43:28] data_word, rest zero
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [2:0] reg_offset, [18:3] value, [20:19] outcome
    logic [2:0]  m_axis_tuser;   // [2:0] action
    logic        m_axis_tlast;

    ata_pio_sector_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // sequencer model state
    // ------------------------------------------------------------------------
    t_phase      seq_phase    = PH_IDLE;
    logic        xfer_is_write = 1'b0;
    logic [27:0] xfer_lba     = '0;
    logic [16:0] polls_left   = '0;
    logic [8:0]  words_left   = '0;
    logic [16:0] poll_limit   = POLL_LIMIT_RESET;

    t_result expected_actions[$];

    int n_errors      = 0;
    int n_results     = 0;
    int n_items       = 0;
    int n_ignored     = 0;
    int n_host_words  = 0;
    int done_by_outcome[4] = '{0, 0, 0, 0};
    int cycle_count   = 0;

    // stimulus pacing
    bit          tx_gaps_on = 1'b1;
    int          burst_left = 0;
    bit          rx_stall_on = 1'b1;
    int          hold_left  = 0;
    logic [15:0] stall_pat  = 16'h0;
    int          stall_pos  = 0;

    function automatic logic [16:0] first_poll_budget();
        return (poll_limit == 17'd0) ? 17'd0 : poll_limit - 17'd1;
    endfunction

    function automatic void push_action(input logic [2:0] act, input logic [2:0] off,
                                        input logic [15:0] val, input logic [1:0] oc);
        t_result r;
        r.action     = act;
        r.reg_offset = off;
        r.value      = val;
        r.outcome    = oc;
        r.last       = 1'b0;
        expected_actions.push_back(r);
        if (act == ACT_DONE)
            done_by_outcome[oc]++;
    endfunction

    function automatic void predict_bus_actions(input logic [1:0] cmd, input logic [27:0] lba,
                                                input logic [15:0] word);
        int         n_before;
        logic [7:0] st;
        n_before = expected_actions.size();
        st = word[7:0];
        case (seq_phase)
            PH_IDLE: begin
                if (cmd == CMD_START_RD || cmd == CMD_START_WR) begin
                    xfer_is_write = (cmd == CMD_START_WR);
                    xfer_lba      = lba;
                    polls_left    = first_poll_budget();
                    seq_phase     = PH_WAIT_BSY;
                    push_action(ACT_BYTE_RD, REG_CMD_ST, 16'h0, OC_SUCCESS);
                end
            end
            PH_WAIT_BSY: begin
                if (cmd == CMD_BUS_REPLY) begin
                    if ((st & ST_BSY) == 8'h00) begin
                        push_action(ACT_BYTE_WR, REG_SELECT,
                                    {8'h00, SEL_LBA_BASE | {4'h0, xfer_lba[27:24]}}, OC_SUCCESS);
                        push_action(ACT_BYTE_WR, REG_COUNT, 16'd1, OC_SUCCESS);
                        push_action(ACT_BYTE_WR, REG_LBA_LO, {8'h00, xfer_lba[7:0]}, OC_SUCCESS);
                        push_action(ACT_BYTE_WR, REG_LBA_MID, {8'h00, xfer_lba[15:8]}, OC_SUCCESS);
                        push_action(ACT_BYTE_WR, REG_LBA_HI, {8'h00, xfer_lba[23:16]}, OC_SUCCESS);
                        push_action(ACT_BYTE_WR, REG_CMD_ST,
                                    {8'h00, xfer_is_write ? ATA_WRITE_SECTORS
                                                          : ATA_READ_SECTORS}, OC_SUCCESS);
                        push_action(ACT_BYTE_RD, REG_CMD_ST, 16'h0, OC_SUCCESS);
                        polls_left = first_poll_budget();
                        seq_phase  = PH_WAIT_DRQ;
                    end else if (polls_left == 17'd0) begin
                        push_action(ACT_DONE, REG_DATA, 16'h0, OC_BSY_TIMEOUT);
                        seq_phase = PH_IDLE;
                    end else begin
                        polls_left = polls_left - 17'd1;
                        push_action(ACT_BYTE_RD, REG_CMD_ST, 16'h0, OC_SUCCESS);
                    end
                end
            end
            PH_WAIT_DRQ: begin
                if (cmd == CMD_BUS_REPLY) begin
                    // ERR wins over DRQ
                    if ((st & ST_ERR) != 8'h00) begin
                        push_action(ACT_DONE, REG_DATA, 16'h0, OC_DEV_ERROR);
                        seq_phase = PH_IDLE;
                    end else if ((st & ST_DRQ) != 8'h00) begin
                        words_left = SECTOR_WORDS;
                        if (xfer_is_write) begin
                            seq_phase = PH_WRITE_DATA;
                        end else begin
                            seq_phase = PH_READ_DATA;
                            push_action(ACT_WORD_RD, REG_DATA, 16'h0, OC_SUCCESS);
                        end
                    end else if (polls_left == 17'd0) begin
                        push_action(ACT_DONE, REG_DATA, 16'h0, OC_DRQ_TIMEOUT);
                        seq_phase = PH_IDLE;
                    end else begin
                        polls_left = polls_left - 17'd1;
                        push_action(ACT_BYTE_RD, REG_CMD_ST, 16'h0, OC_SUCCESS);
                    end
                end
            end
            PH_READ_DATA: begin
                if (cmd == CMD_BUS_REPLY) begin
                    push_action(ACT_HOST, REG_DATA, word, OC_SUCCESS);
                    n_host_words++;
                    words_left = (words_left == 9'd0) ? 9'd0 : words_left - 9'd1;
                    if (words_left == 9'd0) begin
                        push_action(ACT_DONE, REG_DATA, 16'h0, OC_SUCCESS);
                        seq_phase = PH_IDLE;
                    end else begin
                        push_action(ACT_WORD_RD, REG_DATA, 16'h0, OC_SUCCESS);
                    end
                end
            end
            PH_WRITE_DATA: begin
                if (cmd == CMD_HOST_WORD) begin
                    push_action(ACT_WORD_WR, REG_DATA, word, OC_SUCCESS);
                    words_left = (words_left == 9'd0) ? 9'd0 : words_left - 9'd1;
                    if (words_left == 9'd0) begin
                        push_action(ACT_DONE, REG_DATA, 16'h0, OC_SUCCESS);
                        seq_phase = PH_IDLE;
                    end
                end
            end
            default: seq_phase = PH_IDLE;
        endcase
        if (expected_actions.size() > n_before)
            expected_actions[expected_actions.size() - 1].last = 1'b1;
    endfunction

    // accepted beats feed the model; config writes update its poll limit
    always @(posedge i_clk) begin : input_monitor
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_bus_actions(s_axis_tuser, s_axis_tdata[27:0], s_axis_tdata[43:28]);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            poll_limit = i_cfg_data;
    end

    always @(posedge i_clk) begin : result_checker
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.action     = m_axis_tuser;
            got.reg_offset = m_axis_tdata[2:0];
            got.value      = m_axis_tdata[18:3];
            got.outcome    = m_axis_tdata[20:19];
            got.last       = m_axis_tlast;
            n_results++;
            if (expected_actions.size() == 0) begin
                $error("result beat with nothing expected: action %0d", got.action);
                n_errors++;
            end else begin
                want = expected_actions.pop_front();
                if (got.action !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, got.action);
                    n_errors++;
                end
                if (got.reg_offset !== want.reg_offset) begin
                    $error("reg_offset: expected %0d, got %0d", want.reg_offset, got.reg_offset);
                    n_errors++;
                end
                if (got.value !== want.value) begin
                    $error("value: expected 0x%04h, got 0x%04h", want.value, got.value);
                    n_errors++;
                end
                if (got.outcome !== want.outcome) begin
                    $error("outcome: expected %0d, got %0d", want.outcome, got.outcome);
                    n_errors++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_actions.size());
            $display("FAIL");
            $finish;
        end
    end

    // output side: random stall pattern, or a long hold-off when asked
    always @(negedge i_clk) begin : rx_pacing
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left = hold_left - 1;
        end else if (!rx_stall_on) begin
            m_axis_tready = 1'b1;
        end else begin
            m_axis_tready = !stall_pat[stall_pos];
            if (stall_pos == 15) begin
                stall_pos = 0;
                stall_pat = 16'($urandom & $urandom);
            end else begin
                stall_pos++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic [27:0] lba,
                             input logic [15:0] word);
        int gap;
        if (tx_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {4'h0, word, lba};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0)
            burst_left--;
        n_items++;
    endtask

    // a beat whose cmd does not fit where the sequence stands
    task automatic maybe_noise(input t_phase at);
        logic [1:0] cmd;
        if ($urandom_range(0, 11) == 0) begin
            case (at)
                PH_IDLE:       cmd = $urandom_range(0, 1) ? CMD_BUS_REPLY : CMD_HOST_WORD;
                PH_WRITE_DATA: cmd = $urandom_range(0, 1) ? CMD_BUS_REPLY
                                   : ($urandom_range(0, 1) ? CMD_START_RD : CMD_START_WR);
                default:       cmd = $urandom_range(0, 1) ? CMD_HOST_WORD
                                   : ($urandom_range(0, 1) ? CMD_START_RD : CMD_START_WR);
            endcase
            send_item(cmd, 28'($urandom), 16'($urandom));
            n_ignored++;
        end
    endtask

    function automatic logic [15:0] busy_status();
        logic [15:0] w;
        w = 16'($urandom);
        w[7] = 1'b1;
        return w;
    endfunction

    function automatic logic [15:0] ready_status();
        logic [15:0] w;
        w = 16'($urandom);
        w[7] = 1'b0;
        return w;
    endfunction

    function automatic logic [15:0] drq_status(input bit err, input bit drq);
        logic [15:0] w;
        w = 16'($urandom);
        w[0] = err;
        w[3] = drq;
        return w;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (expected_actions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_poll_limit(input logic [16:0] lim);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = lim;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one whole transfer, from start beat to the chosen ending
    task automatic run_transfer(input bit is_wr, input logic [27:0] lba, input t_ending ending,
                                input bit noisy);
        int budget;
        int polls;
        budget = (poll_limit == 17'd0) ? 1 : int'(poll_limit);
        if (noisy) maybe_noise(PH_IDLE);
        send_item(is_wr ? CMD_START_WR : CMD_START_RD, lba, 16'($urandom));
        if (ending == XF_BSY_TIMEOUT) begin
            repeat (budget) begin
                if (noisy) maybe_noise(PH_WAIT_BSY);
                send_item(CMD_BUS_REPLY, 28'($urandom), busy_status());
            end
            return;
        end
        polls = $urandom_range(0, (budget > 4) ? 3 : budget - 1);
        repeat (polls) begin
            if (noisy) maybe_noise(PH_WAIT_BSY);
            send_item(CMD_BUS_REPLY, 28'($urandom), busy_status());
        end
        send_item(CMD_BUS_REPLY, 28'($urandom), ready_status());
        if (ending == XF_DRQ_TIMEOUT) begin
            repeat (budget) begin
                if (noisy) maybe_noise(PH_WAIT_DRQ);
                send_item(CMD_BUS_REPLY, 28'($urandom), drq_status(1'b0, 1'b0));
            end
            return;
        end
        polls = $urandom_range(0, (budget > 4) ? 3 : budget - 1);
        repeat (polls) begin
            if (noisy) maybe_noise(PH_WAIT_DRQ);
            send_item(CMD_BUS_REPLY, 28'($urandom), drq_status(1'b0, 1'b0));
        end
        if (ending == XF_DEV_ERROR) begin
            send_item(CMD_BUS_REPLY, 28'($urandom), drq_status(1'b1, 1'($urandom)));
            return;
        end
        send_item(CMD_BUS_REPLY, 28'($urandom), drq_status(1'b0, 1'b1));
        repeat (int'(SECTOR_WORDS)) begin
            if (noisy) maybe_noise(is_wr ? PH_WRITE_DATA : PH_READ_DATA);
            send_item(is_wr ? CMD_HOST_WORD : CMD_BUS_REPLY, 28'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_ignored_items();
        send_item(CMD_BUS_REPLY, 28'h0FFFFFF, 16'hFFFF);
        send_item(CMD_HOST_WORD, 28'h0, 16'h0000);
        n_ignored += 2;
    endtask

    task automatic test_busy_timeout();
        set_poll_limit(17'd1);
        send_item(CMD_START_RD, 28'hFFFFFFF, 16'h0000);
        send_item(CMD_BUS_REPLY, 28'h0, 16'hFFFF);
        // zero limit still allows the first status read
        set_poll_limit(17'd0);
        send_item(CMD_START_WR, 28'($urandom), 16'hFFFF);
        send_item(CMD_BUS_REPLY, 28'hFFFFFFF, 16'h0080);
    endtask

    task automatic test_device_error();
        set_poll_limit(17'd1);
        send_item(CMD_START_WR, 28'h0000000, 16'h5555);
        send_item(CMD_BUS_REPLY, 28'h0, 16'hFF7F);
        send_item(CMD_START_RD, 28'h1234567, 16'h0);
        send_item(CMD_HOST_WORD, 28'h0, 16'hAAAA);
        n_ignored += 2;
        send_item(CMD_BUS_REPLY, 28'h0, 16'h0001);
        set_poll_limit(17'd3);
        send_item(CMD_START_RD, 28'h5A5A5A5, 16'h0);
        send_item(CMD_BUS_REPLY, 28'h0, 16'h0080);
        send_item(CMD_BUS_REPLY, 28'h0, 16'h00FF);
        send_item(CMD_BUS_REPLY, 28'h0, 16'h0000);
        send_item(CMD_BUS_REPLY, 28'h0, 16'h00F6);
        send_item(CMD_BUS_REPLY, 28'h0, 16'h0004);
        send_item(CMD_BUS_REPLY, 28'h0, 16'hFF09);
    endtask

    task automatic test_drq_timeout();
        set_poll_limit(17'd1);
        send_item(CMD_START_RD, 28'hA5A5A5A, 16'h0);
        send_item(CMD_BUS_REPLY, 28'h0, 16'h7F00);
        send_item(CMD_BUS_REPLY, 28'h0, 16'hFFF6);
    endtask

    // sink holds off long enough for the sequencer to back up into its input
    task automatic test_output_backpressure();
        set_poll_limit(17'd4);
        tx_gaps_on = 1'b0;
        @(posedge i_clk);
        hold_left = 300;
        run_transfer(1'b0, 28'($urandom), XF_DEV_ERROR, 1'b0);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_transfers();
        int      start_items;
        int      budget;
        int      pick;
        bit      did_full;
        bit      is_wr;
        t_ending ending;
        start_items = n_items;
        did_full = 1'b0;
        set_poll_limit(POLL_LIMIT_MAX);
        while ((n_items - start_items) < RANDOM_ITEMS || !did_full) begin
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 9))
                    0:       set_poll_limit(17'd0);
                    1:       set_poll_limit(POLL_LIMIT_MAX);
                    2:       set_poll_limit(POLL_LIMIT_RESET);
                    default: set_poll_limit(17'($urandom_range(1, 6)));
                endcase
            end
            tx_gaps_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            budget = (poll_limit == 17'd0) ? 1 : int'(poll_limit);
            is_wr  = 1'($urandom);
            pick   = $urandom_range(0, 8);
            if (pick < 3 || budget > 8)
                ending = XF_DEV_ERROR;
            else if (pick < 6)
                ending = XF_BSY_TIMEOUT;
            else
                ending = XF_DRQ_TIMEOUT;
            // one full sector keeps the run near its item budget
            if (!did_full && (n_items - start_items) >= 40) begin
                ending   = XF_SUCCESS;
                did_full = 1'b1;
            end
            run_transfer(is_wr, 28'($urandom), ending, 1'b1);
        end
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_START_RD;
        m_axis_tready = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_ignored_items();
        test_busy_timeout();
        test_device_error();
        test_drq_timeout();
        test_output_backpressure();
        test_random_transfers();
        wait_drained();

        $display("covered %0d input beats (%0d out of phase), %0d result beats, %0d host words",
                 n_items, n_ignored, n_results, n_host_words);
        $display("done outcomes: success %0d, device error %0d, busy timeout %0d, drq timeout %0d",
                 done_by_outcome[0], done_by_outcome[1], done_by_outcome[2], done_by_outcome[3]);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/apss_pkg.sv
src/apss_phase_ctrl.sv
src/apss_result_gen.sv
src/ata_pio_sector_sequencer.sv
src/apss_checker.sv
verif/tb_top.sv
